[design/mk_pkg.sv]
package mk_pkg;

  localparam int SPEED_WIDTH = 16;
  localparam int FRAC_BITS   = 8;

  localparam int CFG_WIDTH   = 16;
  localparam int ADDR_WIDTH  = 3;
  localparam int APB_WIDTH   = 32;
  localparam int PWM_WIDTH   = 9;
  localparam int PWM_MAG_W   = PWM_WIDTH - 1;
  localparam int LSUM_FRAC   = 12;
  localparam int WZ_SHIFT    = 10;
  localparam int AVG_SHIFT   = 2;
  localparam int NUM_LANES   = 4;

  localparam logic [PWM_MAG_W-1:0] PWM_FULL        = 8'd255;
  localparam logic [CFG_WIDTH-1:0] L_SUM_RESET     = 16'd1229;
  localparam logic [CFG_WIDTH-1:0] MAX_SPEED_RESET = 16'd256;
  localparam logic [CFG_WIDTH-1:0] LIMIT_ONE       = 16'd256;

  localparam logic CMD_FWD = 1'b0;
  localparam logic CMD_INV = 1'b1;

  localparam logic REG_L_SUM     = 1'b0;
  localparam logic REG_MAX_SPEED = 1'b1;

  // wheel order inside an item and lane order
  localparam int WHL_FL = 0;
  localparam int WHL_FR = 1;
  localparam int WHL_RL = 2;
  localparam int WHL_RR = 3;

  // what a lane does for a forward command
  localparam logic [1:0] KIND_DIV  = 2'd0;
  localparam logic [1:0] KIND_SUM  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  localparam logic [1:0] LANE_KIND [NUM_LANES] = '{KIND_DIV, KIND_SUM, KIND_SUM, KIND_NONE};

  // negated wheels per lane in forward mode, bit order fl fr rl rr
  localparam logic [3:0] FWD_NEG [NUM_LANES] = '{4'b0101, 4'b0000, 4'b1001, 4'b0000};

  // inverse mode: sign of vy and of the yaw term for each wheel
  localparam logic [NUM_LANES-1:0] INV_VY_NEG  = 4'b1001;
  localparam logic [NUM_LANES-1:0] INV_ROT_NEG = 4'b0101;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] l_sum;
    logic [CFG_WIDTH-1:0] max_speed;
  } cfg_t;

endpackage

[design/mk_in_if.sv]
interface mk_in_if #(
  parameter int SPEED_WIDTH = mk_pkg::SPEED_WIDTH
);
  logic                          valid;
  logic                          ready;
  logic                          command;
  logic signed [SPEED_WIDTH-1:0] vx_in;
  logic signed [SPEED_WIDTH-1:0] vy_in;
  logic signed [SPEED_WIDTH-1:0] wz_in;
  logic signed [SPEED_WIDTH-1:0] wheel_fl_in;
  logic signed [SPEED_WIDTH-1:0] wheel_fr_in;
  logic signed [SPEED_WIDTH-1:0] wheel_rl_in;
  logic signed [SPEED_WIDTH-1:0] wheel_rr_in;

  modport source (
    output valid, command, vx_in, vy_in, wz_in,
    output wheel_fl_in, wheel_fr_in, wheel_rl_in, wheel_rr_in,
    input  ready
  );

  modport sink (
    input  valid, command, vx_in, vy_in, wz_in,
    input  wheel_fl_in, wheel_fr_in, wheel_rl_in, wheel_rr_in,
    output ready
  );
endinterface

[design/mk_out_if.sv]
interface mk_out_if #(
  parameter int SPEED_WIDTH = mk_pkg::SPEED_WIDTH
);
  logic                                 valid;
  logic                                 ready;
  logic signed [SPEED_WIDTH-1:0]        vx_out;
  logic signed [SPEED_WIDTH-1:0]        vy_out;
  logic signed [SPEED_WIDTH-1:0]        wz_out;
  logic signed [SPEED_WIDTH-1:0]        wheel_fl_out;
  logic signed [SPEED_WIDTH-1:0]        wheel_fr_out;
  logic signed [SPEED_WIDTH-1:0]        wheel_rl_out;
  logic signed [SPEED_WIDTH-1:0]        wheel_rr_out;
  logic signed [mk_pkg::PWM_WIDTH-1:0]  pwm_fl;
  logic signed [mk_pkg::PWM_WIDTH-1:0]  pwm_fr;
  logic signed [mk_pkg::PWM_WIDTH-1:0]  pwm_rl;
  logic signed [mk_pkg::PWM_WIDTH-1:0]  pwm_rr;

  modport source (
    output valid, vx_out, vy_out, wz_out,
    output wheel_fl_out, wheel_fr_out, wheel_rl_out, wheel_rr_out,
    output pwm_fl, pwm_fr, pwm_rl, pwm_rr,
    input  ready
  );

  modport sink (
    input  valid, vx_out, vy_out, wz_out,
    input  wheel_fl_out, wheel_fr_out, wheel_rl_out, wheel_rr_out,
    input  pwm_fl, pwm_fr, pwm_rl, pwm_rr,
    output ready
  );
endinterface

[design/mk_regs.sv]
module mk_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mk_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [mk_pkg::APB_WIDTH-1:0]    pwdata,
  output logic [mk_pkg::APB_WIDTH-1:0]    prdata,
  output logic                            pready,
  output mk_pkg::cfg_t                    cfg_o
);

  logic [mk_pkg::CFG_WIDTH-1:0] l_sum_r;
  logic [mk_pkg::CFG_WIDTH-1:0] max_speed_r;
  logic                         reg_idx;

  assign reg_idx = paddr[mk_pkg::ADDR_WIDTH-1];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_sum_r     <= mk_pkg::L_SUM_RESET;
      max_speed_r <= mk_pkg::MAX_SPEED_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        mk_pkg::REG_L_SUM:     l_sum_r     <= pwdata[mk_pkg::CFG_WIDTH-1:0];
        mk_pkg::REG_MAX_SPEED: max_speed_r <= pwdata[mk_pkg::CFG_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      mk_pkg::REG_L_SUM:     prdata = mk_pkg::APB_WIDTH'(l_sum_r);
      mk_pkg::REG_MAX_SPEED: prdata = mk_pkg::APB_WIDTH'(max_speed_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg_o.l_sum     = l_sum_r;
  assign cfg_o.max_speed = max_speed_r;

endmodule

[design/mk_div.sv]
// restoring divider, one quotient bit per stage, fully pipelined
module mk_div #(
  parameter int NW = 41,
  parameter int DW = 28,
  parameter int QB = 16,
  parameter int TW = 18
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n_i,
  input  logic [DW-1:0] d_i,
  input  logic [TW-1:0] tag_i,
  output logic [QB-1:0] q_o,
  output logic          ovf_o,
  output logic [TW-1:0] tag_o
);

  localparam int CW = ((NW > DW + QB) ? NW : DW + QB) + 1;

  logic [NW-1:0] rem_r [QB+1];
  logic [QB-1:0] quo_r [QB+1];
  logic [DW-1:0] dv_r  [QB+1];
  logic          ovf_r [QB+1];
  logic [TW-1:0] tag_r [QB+1];

  // first stage: registers the operands and flags a quotient that would not fit in QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_i;
      quo_r[0] <= '0;
      dv_r[0]  <= d_i;
      ovf_r[0] <= (CW'(n_i) >= (CW'(d_i) << QB));
      tag_r[0] <= tag_i;
    end
  end

  for (genvar s = 1; s <= QB; s++) begin : g_step
    localparam int B = QB - s;
    logic [CW-1:0] trial;
    logic          fits;
    logic [QB-1:0] quo_nxt;

    always_comb begin
      trial      = CW'(rem_r[s-1]) - (CW'(dv_r[s-1]) << B);
      fits       = ~trial[CW-1];
      quo_nxt    = quo_r[s-1];
      quo_nxt[B] = fits;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= fits ? trial[NW-1:0] : rem_r[s-1];
        quo_r[s] <= quo_nxt;
        dv_r[s]  <= dv_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign q_o   = quo_r[QB];
  assign ovf_o = ovf_r[QB];
  assign tag_o = tag_r[QB];

endmodule

[design/mk_lane.sv]
// one wheel lane: inverse wheel speed and pwm, or a forward body term
module mk_lane #(
  parameter int SW   = mk_pkg::SPEED_WIDTH,
  parameter int FB   = mk_pkg::FRAC_BITS,
  parameter int LANE = 0
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic                                cmd_i,
  input  logic signed [SW-1:0]                vx_i,
  input  logic signed [SW-1:0]                vy_i,
  input  logic signed [SW-1:0]                wz_i,
  input  logic signed [SW-1:0]                whl_i [mk_pkg::NUM_LANES],
  input  mk_pkg::cfg_t                        cfg_i,
  output logic signed [SW-1:0]                spd_o,
  output logic signed [mk_pkg::PWM_WIDTH-1:0] pwm_o
);

  localparam int CFW = mk_pkg::CFG_WIDTH;
  localparam int WW  = SW + CFW + 1;
  localparam int FW  = SW + 2;
  localparam int NW  = WW + mk_pkg::PWM_MAG_W;
  localparam int DW  = CFW + FB + 4;
  localparam int QB  = SW;
  localparam int TW  = SW + 2;
  localparam int PW  = mk_pkg::PWM_WIDTH;

  localparam logic [1:0] KIND = mk_pkg::LANE_KIND[LANE];
  localparam logic [3:0] FNEG = mk_pkg::FWD_NEG[LANE];
  localparam logic       VNEG = mk_pkg::INV_VY_NEG[LANE];
  localparam logic       RNEG = mk_pkg::INV_ROT_NEG[LANE];

  localparam logic [SW-1:0] SPD_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic [SW-1:0] SPD_MIN = {1'b1, {(SW-1){1'b0}}};

  // stage 1: wheel sums, vx +- vy, yaw product
  logic signed [FW-1:0]  fsum_c;
  logic signed [SW:0]    vsum_c;
  logic signed [CFW:0]   ls_s;
  logic signed [WW-1:0]  prod_c;

  logic                  md1_r;
  logic signed [FW-1:0]  fsum1_r;
  logic signed [SW:0]    vsum1_r;
  logic signed [WW-1:0]  prod1_r;

  always_comb begin
    fsum_c = '0;
    for (int k = 0; k < mk_pkg::NUM_LANES; k++) begin
      if (FNEG[k]) fsum_c = fsum_c - FW'(whl_i[k]);
      else         fsum_c = fsum_c + FW'(whl_i[k]);
    end
  end

  assign vsum_c = VNEG ? ((SW+1)'(vx_i) - (SW+1)'(vy_i)) : ((SW+1)'(vx_i) + (SW+1)'(vy_i));
  assign ls_s   = $signed({1'b0, cfg_i.l_sum});
  assign prod_c = ls_s * wz_i;

  always_ff @(posedge clk) begin
    if (en) begin
      md1_r   <= cmd_i;
      fsum1_r <= fsum_c;
      vsum1_r <= vsum_c;
      prod1_r <= prod_c;
    end
  end

  // stage 2: exact wheel value in Q.(FB+12)
  logic signed [WW-1:0] w_c;
  logic                 md2_r;
  logic signed [FW-1:0] fsum2_r;
  logic signed [WW-1:0] w2_r;

  assign w_c = RNEG ? ((WW'(vsum1_r) <<< mk_pkg::LSUM_FRAC) - prod1_r)
                    : ((WW'(vsum1_r) <<< mk_pkg::LSUM_FRAC) + prod1_r);

  always_ff @(posedge clk) begin
    if (en) begin
      md2_r   <= md1_r;
      fsum2_r <= fsum1_r;
      w2_r    <= w_c;
    end
  end

  // stage 3: magnitude and divisor, truncated and saturated wheel speed
  logic signed [WW-1:0]  ws;
  logic                  ws_fits;
  logic [SW-1:0]         wheel_c;
  logic [WW-1:0]         mag_inv;
  logic [FW-1:0]         fmag;
  logic signed [FW-1:0]  fq;
  logic [CFW-1:0]        lim;
  logic [CFW-1:0]        ls_div;
  logic [NW-1:0]         n_c;
  logic [DW-1:0]         d_c;
  logic [TW-1:0]         tag_c;

  logic [NW-1:0]         n3_r;
  logic [DW-1:0]         d3_r;
  logic [TW-1:0]         tag3_r;

  always_comb begin
    ws      = w2_r >>> mk_pkg::LSUM_FRAC;
    ws_fits = (&ws[WW-1:SW-1]) | ~(|ws[WW-1:SW-1]);
    wheel_c = ws_fits ? ws[SW-1:0] : (ws[WW-1] ? SPD_MIN : SPD_MAX);
    mag_inv = w2_r[WW-1] ? WW'(-w2_r) : WW'(w2_r);
    fmag    = fsum2_r[FW-1] ? FW'(-fsum2_r) : FW'(fsum2_r);
    fq      = fsum2_r >>> mk_pkg::AVG_SHIFT;
    lim     = (cfg_i.max_speed == '0) ? mk_pkg::LIMIT_ONE : cfg_i.max_speed;
    ls_div  = (cfg_i.l_sum == '0) ? CFW'(1) : cfg_i.l_sum;

    d_c = DW'(ls_div);
    if (md2_r == mk_pkg::CMD_INV) begin
      // times 255 as a shift and a subtract
      n_c   = (NW'(mag_inv) << mk_pkg::PWM_MAG_W) - NW'(mag_inv);
      d_c   = DW'(lim) << (FB + 4);
      tag_c = {md2_r, w2_r[WW-1], wheel_c};
    end else begin
      case (KIND)
        mk_pkg::KIND_DIV: begin
          n_c   = NW'(fmag) << mk_pkg::WZ_SHIFT;
          tag_c = {md2_r, fsum2_r[FW-1], {SW{1'b0}}};
        end
        mk_pkg::KIND_SUM: begin
          n_c   = '0;
          // a quarter of four speeds always fits the speed range
          tag_c = {md2_r, 1'b0, fq[SW-1:0]};
        end
        default: begin
          n_c   = '0;
          tag_c = {md2_r, 1'b0, {SW{1'b0}}};
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r   <= n_c;
      d3_r   <= d_c;
      tag3_r <= tag_c;
    end
  end

  logic [QB-1:0] q_w;
  logic          ovf_w;
  logic [TW-1:0] tag_w;

  mk_div #(
    .NW (NW),
    .DW (DW),
    .QB (QB),
    .TW (TW)
  ) u_div (
    .clk   (clk),
    .en    (en),
    .n_i   (n3_r),
    .d_i   (d3_r),
    .tag_i (tag3_r),
    .q_o   (q_w),
    .ovf_o (ovf_w),
    .tag_o (tag_w)
  );

  // sign, clamp and saturation on the quotient
  logic                   neg_w;
  logic                   md_w;
  logic                   pwm_big;
  logic [PW-2:0]          pmag;
  logic signed [PW-1:0]   pval;
  logic                   pos_sat;
  logic                   neg_sat;
  logic [SW-1:0]          q_neg;
  logic [SW-1:0]          wz_c;

  always_comb begin
    neg_w   = tag_w[SW];
    md_w    = tag_w[SW+1];
    pwm_big = ovf_w | (|q_w[QB-1:PW-1]);
    pmag    = pwm_big ? mk_pkg::PWM_FULL : q_w[PW-2:0];
    pval    = $signed({1'b0, pmag});
    pos_sat = ovf_w | q_w[QB-1];
    neg_sat = ovf_w | (q_w[QB-1] & (|q_w[QB-2:0]));
    q_neg   = -q_w;
    if (neg_w) wz_c = neg_sat ? SPD_MIN : q_neg;
    else       wz_c = pos_sat ? SPD_MAX : q_w;

    if (md_w == mk_pkg::CMD_INV) begin
      spd_o = tag_w[SW-1:0];
      pwm_o = neg_w ? -pval : pval;
    end else begin
      spd_o = (KIND == mk_pkg::KIND_DIV) ? wz_c : tag_w[SW-1:0];
      pwm_o = '0;
    end
  end

endmodule

[design/mecanum_kinematics.sv]
// Mecanum wheel kinematics, four wheels, fixed point.
// Input channel in_ch: one word per command. command 0 turns the four wheel
// speeds into body vx, vy and yaw rate; command 1 turns vx, vy and wz into
// four wheel speeds and four pwm duties. Result channel out_ch: one word per
// input word, in order, unused fields zero.
// Registers l_sum and max_linear_speed must be written over the cfg_ port (byte
// addresses 0 and 4) only while no word is in flight; the block does not enforce it.
// Four lanes, one per wheel, each carry a pipelined restoring divider with
// one quotient bit per stage; lane 0 also forms the yaw rate, lanes 1 and 2
// the forward vx and vy. A merge stage picks the fields into the output
// register.
// Path from acceptance to out_ch.valid: input register, lane stages,
// divider and output register. Throughput: one word per cycle while
// the receiver does not stall.
// Reset (rst_n low at a clock edge) empties the pipeline and the output
// register and loads the register defaults.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps taking words until its last stage is full, then in_ch.ready
// drops until the result is taken.
module mecanum_kinematics #(
  parameter int SPEED_WIDTH = mk_pkg::SPEED_WIDTH,
  parameter int FRAC_BITS   = mk_pkg::FRAC_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mk_in_if.sink                           in_ch,
  mk_out_if.source                        out_ch,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [mk_pkg::ADDR_WIDTH-1:0]   cfg_paddr,
  input  logic [mk_pkg::APB_WIDTH-1:0]    cfg_pwdata,
  output logic [mk_pkg::APB_WIDTH-1:0]    cfg_prdata,
  output logic                            cfg_pready
);

  localparam int SW  = SPEED_WIDTH;
  localparam int NL  = mk_pkg::NUM_LANES;
  localparam int PW  = mk_pkg::PWM_WIDTH;
  // input register, three lane stages, divider (SW + 1 stages)
  localparam int NST = SW + 5;

  mk_pkg::cfg_t cfg_w;

  mk_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_o   (cfg_w)
  );

  logic en;
  logic [NST-1:0] vld_r;
  logic [NST-1:0] md_r;
  logic out_valid_r;

  // pipeline moves unless the last stage holds a word the output cannot take
  assign en          = ~vld_r[NST-1] | ~out_valid_r | out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      md_r <= {md_r[NST-2:0], in_ch.command};
    end
  end

  logic                 cmd_r;
  logic signed [SW-1:0] vx_r;
  logic signed [SW-1:0] vy_r;
  logic signed [SW-1:0] wz_r;
  logic signed [SW-1:0] whl_r [NL];

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_r                 <= in_ch.command;
      vx_r                  <= in_ch.vx_in;
      vy_r                  <= in_ch.vy_in;
      wz_r                  <= in_ch.wz_in;
      whl_r[mk_pkg::WHL_FL] <= in_ch.wheel_fl_in;
      whl_r[mk_pkg::WHL_FR] <= in_ch.wheel_fr_in;
      whl_r[mk_pkg::WHL_RL] <= in_ch.wheel_rl_in;
      whl_r[mk_pkg::WHL_RR] <= in_ch.wheel_rr_in;
    end
  end

  logic signed [SW-1:0] spd_w [NL];
  logic signed [PW-1:0] pwm_w [NL];

  for (genvar l = 0; l < NL; l++) begin : g_lane
    mk_lane #(
      .SW   (SW),
      .FB   (FRAC_BITS),
      .LANE (l)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .cmd_i (cmd_r),
      .vx_i  (vx_r),
      .vy_i  (vy_r),
      .wz_i  (wz_r),
      .whl_i (whl_r),
      .cfg_i (cfg_w),
      .spd_o (spd_w[l]),
      .pwm_o (pwm_w[l])
    );
  end

  // merge stage and output register
  logic signed [SW-1:0] vx_o_r;
  logic signed [SW-1:0] vy_o_r;
  logic signed [SW-1:0] wz_o_r;
  logic signed [SW-1:0] whl_o_r [NL];
  logic signed [PW-1:0] pwm_o_r [NL];
  logic                 fwd;

  assign fwd = (md_r[NST-1] == mk_pkg::CMD_FWD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en && vld_r[NST-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && vld_r[NST-1]) begin
      vx_o_r <= fwd ? spd_w[mk_pkg::WHL_FR] : '0;
      vy_o_r <= fwd ? spd_w[mk_pkg::WHL_RL] : '0;
      wz_o_r <= fwd ? spd_w[mk_pkg::WHL_FL] : '0;
      for (int k = 0; k < NL; k++) begin
        whl_o_r[k] <= fwd ? '0 : spd_w[k];
        pwm_o_r[k] <= fwd ? '0 : pwm_w[k];
      end
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.vx_out       = vx_o_r;
  assign out_ch.vy_out       = vy_o_r;
  assign out_ch.wz_out       = wz_o_r;
  assign out_ch.wheel_fl_out = whl_o_r[mk_pkg::WHL_FL];
  assign out_ch.wheel_fr_out = whl_o_r[mk_pkg::WHL_FR];
  assign out_ch.wheel_rl_out = whl_o_r[mk_pkg::WHL_RL];
  assign out_ch.wheel_rr_out = whl_o_r[mk_pkg::WHL_RR];
  assign out_ch.pwm_fl       = pwm_o_r[mk_pkg::WHL_FL];
  assign out_ch.pwm_fr       = pwm_o_r[mk_pkg::WHL_FR];
  assign out_ch.pwm_rl       = pwm_o_r[mk_pkg::WHL_RL];
  assign out_ch.pwm_rr       = pwm_o_r[mk_pkg::WHL_RR];

endmodule

[design/mk_checker.sv]
module mk_checker #(
  parameter int SW = mk_pkg::SPEED_WIDTH
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [SW-1:0]                   vx_out,
  input logic [SW-1:0]                   vy_out,
  input logic [SW-1:0]                   wz_out,
  input logic [SW-1:0]                   wheel_fl_out,
  input logic [SW-1:0]                   wheel_fr_out,
  input logic [SW-1:0]                   wheel_rl_out,
  input logic [SW-1:0]                   wheel_rr_out,
  input logic [mk_pkg::PWM_WIDTH-1:0]    pwm_fl,
  input logic [mk_pkg::PWM_WIDTH-1:0]    pwm_fr,
  input logic [mk_pkg::PWM_WIDTH-1:0]    pwm_rl,
  input logic [mk_pkg::PWM_WIDTH-1:0]    pwm_rr
);

  localparam int PW = mk_pkg::PWM_WIDTH;
  localparam logic [PW-1:0] PWM_BAD = {1'b1, {(PW-1){1'b0}}};

  // a stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({vx_out, vy_out, wz_out, wheel_fl_out, wheel_fr_out,
               wheel_rl_out, wheel_rr_out, pwm_fl, pwm_fr, pwm_rl, pwm_rr}))
    else $error("result changed while stalled");

  // body fields and wheel fields never show together
  a_modes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (vx_out != '0 || vy_out != '0 || wz_out != '0) |->
      wheel_fl_out == '0 && wheel_fr_out == '0 && wheel_rl_out == '0 &&
      wheel_rr_out == '0 && pwm_fl == '0 && pwm_fr == '0 &&
      pwm_rl == '0 && pwm_rr == '0)
    else $error("forward and inverse fields mixed");

  a_pwm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pwm_fl != PWM_BAD && pwm_fr != PWM_BAD &&
                  pwm_rl != PWM_BAD && pwm_rr != PWM_BAD)
    else $error("pwm outside clamp range");

  // a reverse duty comes only with a reverse wheel speed
  a_pwm_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!pwm_fl[PW-1] || wheel_fl_out[SW-1]) &&
                  (!pwm_fr[PW-1] || wheel_fr_out[SW-1]) &&
                  (!pwm_rl[PW-1] || wheel_rl_out[SW-1]) &&
                  (!pwm_rr[PW-1] || wheel_rr_out[SW-1]))
    else $error("pwm sign disagrees with wheel speed");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind mecanum_kinematics mk_checker #(
  .SW (SPEED_WIDTH)
) u_mk_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .vx_out       (out_ch.vx_out),
  .vy_out       (out_ch.vy_out),
  .wz_out       (out_ch.wz_out),
  .wheel_fl_out (out_ch.wheel_fl_out),
  .wheel_fr_out (out_ch.wheel_fr_out),
  .wheel_rl_out (out_ch.wheel_rl_out),
  .wheel_rr_out (out_ch.wheel_rr_out),
  .pwm_fl       (out_ch.pwm_fl),
  .pwm_fr       (out_ch.pwm_fr),
  .pwm_rl       (out_ch.pwm_rl),
  .pwm_rr       (out_ch.pwm_rr)
);
